// File: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Shared word types, action codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Action codes carried in the input word.
  typedef enum logic [1:0] {
    ACT_STREAM = 2'd0,
    ACT_PLACE  = 2'd1,
    ACT_READ   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  localparam int CURSOR_W = 11;
  localparam int CELL_W   = 16;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
  localparam logic [7:0]        CH_NUL     = 8'h00;
  localparam logic [7:0]        CH_TAB     = 8'h09;
  localparam logic [7:0]        CH_NEWLINE = 8'h0A;
  localparam logic [7:0]        CH_SPACE   = 8'h20;

  // Input word.
  typedef struct packed {
    action_e    action;
    logic [7:0] char_code;
    logic [7:0] color;
    logic [6:0] column;
    logic [4:0] row;
  } in_t;

  // Result word.
  typedef struct packed {
    logic [CELL_W-1:0]   cell_value;
    logic [CURSOR_W-1:0] cursor_position;
    logic                scrolled;
    logic                bad_position;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // latch the input word
    logic exec;    // first step of the latched word
    logic copy;    // one step of the scroll copy
    logic fill;    // write one blank cell at the sweep counter
    logic emit;    // load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_e action;
    logic    on_screen;
    logic    need_scroll;
    logic    copy_last;
    logic    fill_last;
  } dp_status_t;

endpackage

// File: rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// Text console screen memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int Depth = 2000,
  parameter int AddrW = 11
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AddrW-1:0]              waddr_i,
  input  logic [tcw_pkg::CELL_W-1:0]    wdata_i,
  input  logic                          re_i,
  input  logic [AddrW-1:0]              raddr_i,
  output logic [tcw_pkg::CELL_W-1:0]    rdata_o
);

  logic [tcw_pkg::CELL_W-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// Text console writer controller
// Sequences reset sweep, word execution, read wait, scroll copy and fill.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  tcw_pkg::dp_status_t status_i,
  output tcw_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_INIT = 6'b000001,
    S_IDLE = 6'b000010,
    S_EXEC = 6'b000100,
    S_READ = 6'b001000,
    S_COPY = 6'b010000,
    S_FILL = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    unique case (state_q)
      S_INIT: begin
        cmd_o.fill = 1'b1;
        if (status_i.fill_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        unique case (status_i.action)
          tcw_pkg::ACT_STREAM: begin
            if (status_i.need_scroll) begin
              state_d = S_COPY;
            end else begin
              cmd_o.emit = 1'b1;
              state_d    = S_IDLE;
            end
          end
          tcw_pkg::ACT_PLACE: begin
            cmd_o.emit = 1'b1;
            state_d    = S_IDLE;
          end
          tcw_pkg::ACT_READ: begin
            if (status_i.on_screen) begin
              state_d = S_READ;
            end else begin
              cmd_o.emit = 1'b1;
              state_d    = S_IDLE;
            end
          end
          tcw_pkg::ACT_CLEAR: begin
            state_d = S_FILL;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end
      S_COPY: begin
        cmd_o.copy = 1'b1;
        if (status_i.copy_last) begin
          state_d = S_FILL;
        end
      end
      S_FILL: begin
        cmd_o.fill = 1'b1;
        if (status_i.fill_last) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/tcw_datapath.sv
// ----------------------------------------------------------------------------
// Text console writer datapath
// Word register, cursor, sweep counter, screen memory and result register.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcw_pkg::in_t        item_i,
  input  tcw_pkg::ctrl_cmd_t  cmd_i,
  output tcw_pkg::dp_status_t status_o,
  output logic                done_o,
  output tcw_pkg::out_t       result_o
);

  localparam int Cells  = COLUMNS * ROWS;
  localparam int CellAw = $clog2(Cells);
  localparam int ColW   = $clog2(COLUMNS);
  localparam int RowW   = $clog2(ROWS);

  typedef logic [tcw_pkg::CURSOR_W-1:0] cur_t;
  typedef logic [tcw_pkg::CELL_W-1:0]   cell_t;

  tcw_pkg::in_t      item_q;
  logic              scroll_q;
  logic [CellAw-1:0] lin_q, lin_d;
  logic [ColW-1:0]   col_q, col_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [CellAw-1:0] cnt_q, cnt_d;
  logic              done_q;
  tcw_pkg::out_t     result_q;

  logic [7:0]        ch_eff;
  logic              is_nl, is_print;
  logic              col_last, row_last;
  logic              on_screen;
  logic              need_scroll;
  logic              copy_last, fill_last;
  logic [CellAw-1:0] pos_addr;
  logic [CellAw-1:0] row_base;

  logic              mem_we, mem_re;
  logic [CellAw-1:0] mem_waddr, mem_raddr;
  cell_t             mem_wdata, mem_rdata;

  // Decode of the latched word.
  assign ch_eff    = (item_q.char_code == tcw_pkg::CH_TAB) ? tcw_pkg::CH_SPACE
                                                           : item_q.char_code;
  assign is_nl     = (ch_eff == tcw_pkg::CH_NEWLINE);
  assign is_print  = (ch_eff != tcw_pkg::CH_NUL) && !is_nl;
  assign col_last  = (col_q == ColW'(COLUMNS - 1));
  assign row_last  = (row_q == RowW'(ROWS - 1));
  assign on_screen = (32'(item_q.column) < COLUMNS) && (32'(item_q.row) < ROWS);
  assign pos_addr  = CellAw'(32'(item_q.column) + COLUMNS * 32'(item_q.row));
  assign row_base  = lin_q - CellAw'(col_q);

  assign need_scroll = (item_q.action == tcw_pkg::ACT_STREAM) && row_last &&
                       (is_nl || (is_print && col_last));
  assign copy_last   = (cnt_q == CellAw'(Cells - COLUMNS));
  assign fill_last   = (cnt_q == CellAw'(Cells - 1));

  assign status_o.action      = item_q.action;
  assign status_o.on_screen   = on_screen;
  assign status_o.need_scroll = need_scroll;
  assign status_o.copy_last   = copy_last;
  assign status_o.fill_last   = fill_last;

  // Cursor update; the scroll is folded in so the cursor is final here.
  always_comb begin
    lin_d = lin_q;
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.exec) begin
      if (item_q.action == tcw_pkg::ACT_CLEAR) begin
        lin_d = '0;
        col_d = '0;
        row_d = '0;
      end else if (item_q.action == tcw_pkg::ACT_STREAM) begin
        if (is_nl) begin
          col_d = '0;
          if (row_last) begin
            lin_d = row_base;
          end else begin
            lin_d = row_base + CellAw'(COLUMNS);
            row_d = row_q + RowW'(1);
          end
        end else if (is_print) begin
          if (col_last) begin
            col_d = '0;
            if (row_last) begin
              lin_d = lin_q - CellAw'(COLUMNS - 1);
            end else begin
              lin_d = lin_q + CellAw'(1);
              row_d = row_q + RowW'(1);
            end
          end else begin
            col_d = col_q + ColW'(1);
            lin_d = lin_q + CellAw'(1);
          end
        end
      end
    end
  end

  // Sweep counter for scroll copy and fill.
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.exec) begin
      cnt_d = '0;
    end else if (cmd_i.copy) begin
      if (!copy_last) begin
        cnt_d = cnt_q + CellAw'(1);
      end
    end else if (cmd_i.fill) begin
      cnt_d = cnt_q + CellAw'(1);
    end
  end

  // Memory port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_q;
    mem_wdata = tcw_pkg::BLANK_CELL;
    mem_re    = 1'b0;
    mem_raddr = pos_addr;
    if (cmd_i.exec) begin
      if (item_q.action == tcw_pkg::ACT_STREAM) begin
        mem_we    = is_print;
        mem_waddr = lin_q;
        mem_wdata = {item_q.color, ch_eff};
      end else if (item_q.action == tcw_pkg::ACT_PLACE) begin
        mem_we    = on_screen;
        mem_waddr = pos_addr;
        mem_wdata = {item_q.color, item_q.char_code};
      end else if (item_q.action == tcw_pkg::ACT_READ) begin
        mem_re = on_screen;
      end
    end else if (cmd_i.copy) begin
      // Read one row ahead, write the previous read one step behind.
      mem_re    = !copy_last;
      mem_raddr = cnt_q + CellAw'(COLUMNS);
      mem_we    = (cnt_q != '0);
      mem_waddr = cnt_q - CellAw'(1);
      mem_wdata = mem_rdata;
    end else if (cmd_i.fill) begin
      mem_we = 1'b1;
    end
  end

  tcw_ram #(
    .Depth (Cells),
    .AddrW (CellAw)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Word register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= item_i;
    end
  end

  // Cursor, counter and scroll flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_q    <= '0;
      col_q    <= '0;
      row_q    <= '0;
      cnt_q    <= '0;
      scroll_q <= 1'b0;
    end else begin
      lin_q <= lin_d;
      col_q <= col_d;
      row_q <= row_d;
      cnt_q <= cnt_d;
      if (cmd_i.accept) begin
        scroll_q <= 1'b0;
      end else if (cmd_i.exec && need_scroll) begin
        scroll_q <= 1'b1;
      end
    end
  end

  // Result register and strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      result_q.cell_value      <= (item_q.action == tcw_pkg::ACT_READ && on_screen)
                                  ? mem_rdata : '0;
      result_q.cursor_position <= cur_t'(lin_d);
      result_q.scrolled        <= scroll_q;
      result_q.bad_position    <= ((item_q.action == tcw_pkg::ACT_PLACE) ||
                                   (item_q.action == tcw_pkg::ACT_READ)) && !on_screen;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// File: rtl/text_console_writer.sv
// Sequence: stream, place and off-screen read words are executed and their result
// is emitted from the exec state; an on-screen read adds a wait for the memory read port.
// A scroll adds a copy sweep plus a bottom-row fill; clear adds a full-screen
// fill. A new word is taken only after the previous word is finished.
// After reset the memory is swept to blank cells with busy high. Results
// are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// Text console writer
// Character-cell screen with a linear write cursor, scrolling and clear.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  tcw_pkg::in_t  item_i,
  output logic          done_o,
  output tcw_pkg::out_t result_o
);

  tcw_pkg::ctrl_cmd_t  cmd;
  tcw_pkg::dp_status_t status;

  // Sequencer.
  tcw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Cursor, screen memory and result.
  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .status_o (status),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

// File: verif/tb_text_console_writer.sv
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives command words into the console writer and checks every result word
// against a cycle-free model of the screen and cursor kept in the bench.
// Directed tests cover reset contents, place and read, off-screen positions,
// the stream control characters, clear and scrolling; random phases then
// stream text lines mixed with place, read, clear and raw words, with the
// sender idling at several rates.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELLS      = COLUMNS * ROWS;
  localparam int CLK_PERIOD = 8;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_WORDS = 1850;
  // Four times a run in which every word waits out a full screen sweep and
  // the longest sender gap.
  localparam longint CYCLE_LIMIT = 4 * (CELLS + (RANDOM_WORDS + 64) * (CELLS + 48));

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  in_t   item_i = '0;
  logic  done_o;
  out_t  result_o;

  // Screen model, cursor model and the results still owed by the block.
  logic [CELL_W-1:0] screen_model [CELLS];
  int unsigned       cursor_model;
  out_t              console_replies[$];
  out_t              due_reply;

  int     sender_idle_pct = 0;
  int     sent_words = 0;
  int     mismatch_count = 0;
  longint cycle_count = 0;

  text_console_writer #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Give up on a hung block.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Apply one word to the screen model and return the result it should give.
  function automatic out_t console_predict(in_t w);
    out_t       r;
    logic [7:0] ch;
    bit         on_screen;
    r = '0;
    ch = w.char_code;
    on_screen = (w.column < COLUMNS) && (w.row < ROWS);
    case (w.action)
      ACT_STREAM: begin
        if (ch == CH_TAB) ch = CH_SPACE;
        if (ch == CH_NEWLINE) begin
          cursor_model = (cursor_model / COLUMNS + 1) * COLUMNS;
        end else if (ch != CH_NUL) begin
          if (cursor_model < CELLS) screen_model[cursor_model] = {w.color, ch};
          cursor_model++;
        end
        // Past the end: move every row up and blank the bottom one.
        if (cursor_model >= CELLS) begin
          for (int i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
          for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = BLANK_CELL;
          cursor_model -= COLUMNS;
          r.scrolled = 1'b1;
        end
      end
      ACT_PLACE: begin
        if (on_screen) screen_model[w.column + COLUMNS * w.row] = {w.color, w.char_code};
        else r.bad_position = 1'b1;
      end
      ACT_READ: begin
        if (on_screen) r.cell_value = screen_model[w.column + COLUMNS * w.row];
        else r.bad_position = 1'b1;
      end
      default: begin
        for (int i = 0; i < CELLS; i++) screen_model[i] = BLANK_CELL;
        cursor_model = 0;
      end
    endcase
    r.cursor_position = cursor_model[CURSOR_W-1:0];
    return r;
  endfunction

  function automatic in_t word_of(action_e act, logic [7:0] ch, logic [7:0] color,
                                  logic [6:0] col, logic [4:0] row);
    in_t w;
    w.action    = act;
    w.char_code = ch;
    w.color     = color;
    w.column    = col;
    w.row       = row;
    return w;
  endfunction

  // Present one word, wait until the block takes it, then idle at random.
  task automatic send_word(in_t w);
    int gap;
    start  <= 1'b1;
    item_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    console_replies.push_back(console_predict(w));
    sent_words++;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic flag_field(string what, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // Every strobed result must match the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (console_replies.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, result_o);
        mismatch_count++;
      end else begin
        due_reply = console_replies.pop_front();
        flag_field("cell_value", due_reply.cell_value, result_o.cell_value);
        flag_field("cursor_position", 16'(due_reply.cursor_position),
                   16'(result_o.cursor_position));
        flag_field("scrolled", 16'(due_reply.scrolled), 16'(result_o.scrolled));
        flag_field("bad_position", 16'(due_reply.bad_position),
                   16'(result_o.bad_position));
      end
    end
  end

  // The screen comes out of reset blank.
  task automatic test_reset_contents();
    send_word(word_of(ACT_READ, 8'h00, 8'h00, 7'd0, 5'd0));
    send_word(word_of(ACT_READ, 8'hFF, 8'hFF, 7'(COLUMNS - 1), 5'(ROWS - 1)));
  endtask

  // Extreme characters and colors at the screen corners read back intact.
  task automatic test_place_read();
    send_word(word_of(ACT_PLACE, 8'hFF, 8'hFF, 7'(COLUMNS - 1), 5'(ROWS - 1)));
    send_word(word_of(ACT_READ, 8'h00, 8'h00, 7'(COLUMNS - 1), 5'(ROWS - 1)));
    send_word(word_of(ACT_PLACE, 8'h00, 8'h00, 7'd0, 5'd0));
    send_word(word_of(ACT_READ, 8'hFF, 8'hFF, 7'd0, 5'd0));
  endtask

  // Positions just off the screen and at the field maximum are refused.
  task automatic test_off_screen();
    send_word(word_of(ACT_PLACE, 8'h41, 8'h07, 7'(COLUMNS), 5'd0));
    send_word(word_of(ACT_PLACE, 8'h41, 8'h07, 7'd0, 5'(ROWS)));
    send_word(word_of(ACT_READ, 8'h00, 8'h00, 7'd127, 5'd31));
  endtask

  // Tab is stored as a space, NUL is dropped, high bytes stay unsigned.
  task automatic test_stream_controls();
    send_word(word_of(ACT_STREAM, CH_TAB, 8'h1F, 7'd0, 5'd0));
    send_word(word_of(ACT_STREAM, CH_NUL, 8'h1F, 7'd0, 5'd0));
    send_word(word_of(ACT_STREAM, 8'hFF, 8'h80, 7'd127, 5'd31));
    send_word(word_of(ACT_STREAM, CH_NEWLINE, 8'h00, 7'd0, 5'd0));
    send_word(word_of(ACT_READ, 8'h00, 8'h00, 7'd0, 5'd0));
    send_word(word_of(ACT_READ, 8'h00, 8'h00, 7'd1, 5'd0));
  endtask

  // Clear blanks the screen and homes the cursor.
  task automatic test_clear();
    send_word(word_of(ACT_CLEAR, 8'hFF, 8'hFF, 7'd127, 5'd31));
    send_word(word_of(ACT_READ, 8'h00, 8'h00, 7'(COLUMNS - 1), 5'(ROWS - 1)));
  endtask

  // A newline on the last row scrolls once and moves a marker up a row.
  task automatic test_scroll_on_newline();
    send_word(word_of(ACT_CLEAR, 8'h00, 8'h00, 7'd0, 5'd0));
    send_word(word_of(ACT_PLACE, 8'h4D, 8'h4E, 7'd5, 5'd1));
    repeat (ROWS) send_word(word_of(ACT_STREAM, CH_NEWLINE, 8'h00, 7'd0, 5'd0));
    send_word(word_of(ACT_READ, 8'h00, 8'h00, 7'd5, 5'd0));
    send_word(word_of(ACT_READ, 8'h00, 8'h00, 7'd5, 5'(ROWS - 1)));
  endtask

  // One line of text, sometimes longer than a row, mostly ended by newline.
  task automatic send_text_line();
    int          len;
    int unsigned pick;
    logic [7:0]  ch;
    len = $urandom_range(90);
    for (int k = 0; k < len; k++) begin
      pick = $urandom_range(99);
      if (pick < 4) ch = CH_TAB;
      else if (pick < 6) ch = CH_NUL;
      else ch = 8'($urandom_range(255));
      send_word(word_of(ACT_STREAM, ch, 8'($urandom_range(255)), 7'($urandom_range(127)),
                        5'($urandom_range(31))));
    end
    if ($urandom_range(3) != 0)
      send_word(word_of(ACT_STREAM, CH_NEWLINE, 8'($urandom_range(255)),
                        7'($urandom_range(127)), 5'($urandom_range(31))));
  endtask

  // A short run of places and reads, some off screen, some at the cursor.
  task automatic send_cell_burst();
    int          len;
    logic [6:0]  col;
    logic [4:0]  row;
    action_e     act;
    len = $urandom_range(1, 6);
    repeat (len) begin
      act = $urandom_range(1) ? ACT_PLACE : ACT_READ;
      if ($urandom_range(99) < 15) begin
        col = 7'($urandom_range(127));
        row = 5'($urandom_range(31));
      end else if (act == ACT_READ && cursor_model != 0 && $urandom_range(2) == 0) begin
        col = 7'((cursor_model - 1) % COLUMNS);
        row = 5'((cursor_model - 1) / COLUMNS);
      end else begin
        col = 7'($urandom_range(COLUMNS - 1));
        row = 5'($urandom_range(ROWS - 1));
      end
      send_word(word_of(act, 8'($urandom_range(255)), 8'($urandom_range(255)), col, row));
    end
  endtask

  // Random console traffic, mostly text, at the given sender idle rate.
  task automatic test_random_console(int idle_pct, int words);
    int          stop_at;
    int unsigned pick;
    logic [31:0] raw_bits;
    sender_idle_pct = idle_pct;
    stop_at = sent_words + words;
    while (sent_words < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        send_text_line();
      end else if (pick < 80) begin
        send_cell_burst();
      end else if (pick < 82) begin
        send_word(word_of(ACT_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)),
                          7'($urandom_range(127)), 5'($urandom_range(31))));
      end else begin
        raw_bits = $urandom;
        send_word(raw_bits[$bits(in_t)-1:0]);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < CELLS; i++) screen_model[i] = BLANK_CELL;
    cursor_model = 0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_contents();
    test_place_read();
    test_off_screen();
    test_stream_controls();
    test_clear();
    test_scroll_on_newline();

    test_random_console(0, RANDOM_WORDS / 4);
    test_random_console(79, RANDOM_WORDS / 4);
    test_random_console(35, RANDOM_WORDS / 4);
    test_random_console(0, RANDOM_WORDS / 4);

    start <= 1'b0;
    while (console_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && console_replies.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
